>>> hw/rtl/rwav_pkg.sv
// Package for the RIFF/WAVE PCM stream decoder: constants and types.
// No dependencies.
`default_nettype none

package rwav_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;
    localparam logic [31:0] MIN_FILE = 32'd44;

    typedef enum logic [2:0] {
        PH_HEAD = 3'd0,
        PH_ID   = 3'd1,
        PH_LEN  = 3'd2,
        PH_BODY = 3'd3,
        PH_PAD  = 3'd4,
        PH_HALT = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_TAG   = 3'd2,
        ST_NO_DATA   = 3'd3,
        ST_BAD_FMT   = 3'd4,
        ST_EARLY     = 3'd5,
        ST_TRUNCATED = 3'd6
    } status_t;

    // Sample width selector for the converter.
    typedef enum logic [1:0] {
        W16 = 2'd0,
        W24 = 2'd1,
        W32 = 2'd2
    } swidth_t;

endpackage

`default_nettype wire

>>> hw/rtl/riff_wav_pcm_stream_decoder_top.sv
// Top level of the RIFF/WAVE PCM stream decoder: header and chunk parser,
// sample assembly and output register. Uses rwav_pkg and rwav_conv.
//
// Usage: file bytes enter on the s_axis channel, one byte per beat, with
// s_axis_tlast on the last byte of the file. Results leave on m_axis: one
// beat when a sample completes or on the last byte (one beat covers both),
// and none for other bytes. m_axis_tlast marks the end-of-file beat, which
// carries the status. m_axis_tuser flags a valid sample in tdata.
// A byte's result is registered in the output register and appears on m_axis
// in the cycle after the byte is accepted. Throughput is one byte per cycle
// while the receiver does not stall; the parser state and the float
// converter are both combinational between the input beat and the output register.
// While the receiver stalls, the result is held in the output register and
// a new byte is accepted only when that register is empty or is taken in
// the same cycle. After the last byte the parser returns to its reset
// state. Reset clears the parser and empties the output register.
`default_nettype none

module riff_wav_pcm_stream_decoder_top
    import rwav_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // sample_bits[31:0], status[34:32],
                                             // channel_count[50:35],
                                             // sample_rate[82:51], zero fill
    output logic             m_axis_tlast,   // end_of_file
    output logic             m_axis_tuser    // has_sample
);

    phase_t      phase_reg,  phase_next;
    logic [31:0] count_reg,  count_next;
    logic [31:0] tag_reg,    tag_next;
    logic [31:0] len_reg,    len_next;
    logic [31:0] off_reg,    off_next;
    logic [15:0] fmt_reg,    fmt_next;
    logic [15:0] chan_reg,   chan_next;
    logic [31:0] rate_reg,   rate_next;
    logic [15:0] bps_reg,    bps_next;
    logic [31:0] asm_reg,    asm_next;
    logic [1:0]  sidx_reg,   sidx_next;
    logic        fmtok_reg,  fmtok_next;
    logic        dataok_reg, dataok_next;
    status_t     err_reg,    err_next;

    logic        ovalid_reg;
    logic [31:0] obits_reg;
    logic [2:0]  ostat_reg;
    logic [15:0] ochan_reg;
    logic [31:0] orate_reg;
    logic        olast_reg;
    logic        ouser_reg;

    logic        take;
    logic        got;
    logic        decodable;
    logic [31:0] asm_full;
    logic [1:0]  nbytes_m1;
    swidth_t     swidth;
    logic [31:0] conv_out;
    status_t     stat;
    logic [31:0] off_inc;
    logic [31:0] pos;
    logic [4:0]  lsh;

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign pos = count_reg;

    // Format check on the latched fmt fields.
    always_comb
    begin
        decodable = 1'b0;
        if (fmtok_reg && chan_reg != 16'd0 && rate_reg != 32'd0)
        begin
            if (fmt_reg == 16'd3)
            begin
                decodable = (bps_reg == 16'd32);
            end
            else if (fmt_reg == 16'd1)
            begin
                decodable = (bps_reg == 16'd16) || (bps_reg == 16'd24) ||
                            (bps_reg == 16'd32);
            end
        end
        case (bps_reg)
            16'd16:  begin swidth = W16; nbytes_m1 = 2'd1; end
            16'd24:  begin swidth = W24; nbytes_m1 = 2'd2; end
            default: begin swidth = W32; nbytes_m1 = 2'd3; end
        endcase
    end

    assign asm_full = asm_reg | ({24'd0, s_axis_tdata} << {sidx_reg, 3'd0});

    rwav_conv u_conv (
        .raw      (asm_full),
        .width    (swidth),
        .is_float (fmt_reg == 16'd3),
        .result   (conv_out)
    );

    // Parser next state for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = (count_reg != 32'hFFFFFFFF) ? count_reg + 32'd1 : count_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        fmt_next    = fmt_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        bps_next    = bps_reg;
        asm_next    = asm_reg;
        sidx_next   = sidx_reg;
        fmtok_next  = fmtok_reg;
        dataok_next = dataok_reg;
        err_next    = err_reg;
        got         = 1'b0;
        off_inc     = off_reg + 32'd1;
        lsh         = {off_reg[1:0], 3'd0};

        case (phase_reg)
            PH_HEAD:
            begin
                tag_next = {tag_reg[23:0], s_axis_tdata};
                if ((pos == 32'd3 && tag_next != TAG_RIFF) ||
                    (pos == 32'd11 && tag_next != TAG_WAVE))
                begin
                    if (err_reg == ST_OK)
                    begin
                        err_next = ST_BAD_TAG;
                    end
                    phase_next = PH_HALT;
                end
                else if (pos == 32'd11)
                begin
                    phase_next = PH_ID;
                    off_next = 32'd0;
                end
            end
            PH_ID:
            begin
                tag_next = {tag_reg[23:0], s_axis_tdata};
                off_next = off_inc;
                if (off_inc >= 32'd4)
                begin
                    phase_next = PH_LEN;
                    off_next = 32'd0;
                    len_next = 32'd0;
                end
            end
            PH_LEN:
            begin
                len_next = len_reg | ({24'd0, s_axis_tdata} << lsh);
                off_next = off_inc;
                if (off_inc >= 32'd4)
                begin
                    off_next = 32'd0;
                    sidx_next = 2'd0;
                    asm_next = 32'd0;
                    if (tag_reg == TAG_DATA)
                    begin
                        dataok_next = 1'b1;
                        if (!fmtok_reg && err_reg == ST_OK)
                        begin
                            err_next = ST_EARLY;
                        end
                    end
                    if (len_next == 32'd0)
                    begin
                        phase_next = PH_ID;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (tag_reg == TAG_FMT && len_reg >= 32'd16 && off_reg < 32'd16)
                begin
                    case (off_reg[3:0])
                        4'd0:  fmt_next[7:0]   = s_axis_tdata;
                        4'd1:  fmt_next[15:8]  = s_axis_tdata;
                        4'd2:  chan_next[7:0]  = s_axis_tdata;
                        4'd3:  chan_next[15:8] = s_axis_tdata;
                        4'd4:  rate_next[7:0]  = s_axis_tdata;
                        4'd5:  rate_next[15:8] = s_axis_tdata;
                        4'd6:  rate_next[23:16] = s_axis_tdata;
                        4'd7:  rate_next[31:24] = s_axis_tdata;
                        4'd14: bps_next[7:0]   = s_axis_tdata;
                        4'd15:
                        begin
                            bps_next[15:8] = s_axis_tdata;
                            fmtok_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
                else if (tag_reg == TAG_DATA && decodable)
                begin
                    if (sidx_reg >= nbytes_m1)
                    begin
                        got = 1'b1;
                        asm_next = 32'd0;
                        sidx_next = 2'd0;
                    end
                    else
                    begin
                        asm_next = asm_full;
                        sidx_next = sidx_reg + 2'd1;
                    end
                end
                off_next = off_inc;
                if (off_inc == len_reg)
                begin
                    off_next = 32'd0;
                    phase_next = len_reg[0] ? PH_PAD : PH_ID;
                end
            end
            PH_PAD:
            begin
                phase_next = PH_ID;
                off_next = 32'd0;
            end
            default: ;
        endcase
    end

    // End-of-file status, in priority order.
    always_comb
    begin
        stat = ST_OK;
        if (count_next < MIN_FILE)
        begin
            stat = ST_SHORT;
        end
        else if (err_next != ST_OK)
        begin
            stat = err_next;
        end
        else if (phase_next == PH_BODY && tag_next == TAG_DATA)
        begin
            stat = ST_TRUNCATED;
        end
        else if (!dataok_next || chan_next == 16'd0 || rate_next == 32'd0)
        begin
            stat = ST_NO_DATA;
        end
        else if (!(fmtok_next &&
                   ((fmt_next == 16'd3 && bps_next == 16'd32) ||
                    (fmt_next == 16'd1 && (bps_next == 16'd16 ||
                     bps_next == 16'd24 || bps_next == 16'd32)))))
        begin
            stat = ST_BAD_FMT;
        end
    end

    // Parser state; the last byte returns it to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            count_reg  <= '0;
            tag_reg    <= '0;
            len_reg    <= '0;
            off_reg    <= '0;
            fmt_reg    <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            bps_reg    <= '0;
            asm_reg    <= '0;
            sidx_reg   <= '0;
            fmtok_reg  <= 1'b0;
            dataok_reg <= 1'b0;
            err_reg    <= ST_OK;
        end
        else if (take)
        begin
            if (s_axis_tlast)
            begin
                phase_reg  <= PH_HEAD;
                count_reg  <= '0;
                tag_reg    <= '0;
                len_reg    <= '0;
                off_reg    <= '0;
                fmt_reg    <= '0;
                chan_reg   <= '0;
                rate_reg   <= '0;
                bps_reg    <= '0;
                asm_reg    <= '0;
                sidx_reg   <= '0;
                fmtok_reg  <= 1'b0;
                dataok_reg <= 1'b0;
                err_reg    <= ST_OK;
            end
            else
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                tag_reg    <= tag_next;
                len_reg    <= len_next;
                off_reg    <= off_next;
                fmt_reg    <= fmt_next;
                chan_reg   <= chan_next;
                rate_reg   <= rate_next;
                bps_reg    <= bps_next;
                asm_reg    <= asm_next;
                sidx_reg   <= sidx_next;
                fmtok_reg  <= fmtok_next;
                dataok_reg <= dataok_next;
                err_reg    <= err_next;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (take)
        begin
            ovalid_reg <= got || s_axis_tlast;
        end
        else if (m_axis_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            obits_reg <= got ? conv_out : 32'd0;
            ostat_reg <= s_axis_tlast ? stat : ST_OK;
            ochan_reg <= chan_next;
            orate_reg <= rate_next;
            olast_reg <= s_axis_tlast;
            ouser_reg <= got;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {5'd0, orate_reg, ochan_reg, ostat_reg, obits_reg};
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = ouser_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rwav_conv.sv
// Converts a signed 16/24/32-bit PCM word to an IEEE single bit pattern,
// scaled to plus or minus 1, or passes a float through. Uses rwav_pkg.
`default_nettype none

module rwav_conv
    import rwav_pkg::*;
(
    input  wire logic [31:0] raw,
    input  wire swidth_t     width,
    input  wire logic        is_float,
    output logic [31:0]      result
);

    logic [31:0] v;
    logic        neg;
    logic [31:0] m;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [24:0] q;
    logic        guard;
    logic        sticky;
    logic [7:0]  bias;
    logic [7:0]  expo;

    // Sign-extend to 32 bits and take the magnitude.
    always_comb
    begin
        case (width)
            W16:     v = {{16{raw[15]}}, raw[15:0]};
            W24:     v = {{8{raw[23]}}, raw[23:0]};
            default: v = raw;
        endcase
        neg = v[31];
        m = neg ? (~v + 32'd1) : v;
    end

    // Leading one search by priority scan.
    always_comb
    begin
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (m[i])
            begin
                p = 5'(i);
            end
        end
    end

    // Align the leading one to bit 31, then round to 24 bits, nearest even.
    always_comb
    begin
        norm = m << (5'd31 - p);
        guard = norm[7];
        sticky = |norm[6:0];
        q = {1'b0, norm[31:8]};
        if (guard && (sticky || norm[8]))
        begin
            q = q + 25'd1;
        end
        case (width)
            W16:     bias = 8'd112;
            W24:     bias = 8'd104;
            default: bias = 8'd96;
        endcase
        expo = bias + {3'd0, p} + {7'd0, q[24]};
    end

    always_comb
    begin
        if (is_float)
        begin
            result = raw;
        end
        else if (m == 32'd0)
        begin
            result = 32'd0;
        end
        else
        begin
            result = {neg, expo, q[24] ? q[23:1] : q[22:0]};
        end
    end

endmodule

`default_nettype wire
